[hw/rtl/fixed_point_natural_log_macros.svh]
// Assertion macros shared by the checker of the fixed-point natural logarithm.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef FIXED_POINT_NATURAL_LOG_MACROS_SVH
`define FIXED_POINT_NATURAL_LOG_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FPNL_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define FPNL_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/fpnl_pkg.sv]
// Package for the fixed-point natural logarithm: default parameters and constants.
// Depends on nothing; used by the top level, the front end, the squaring stage, the scaling stage and the checker.
package fpnl_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Width of the result field.
  localparam int LOG_W = 21;

  // ln 2 in Q31, held as a positive signed constant.
  localparam int LN2_W     = 32;
  localparam int LN2_SHIFT = 31;
  localparam logic signed [LN2_W-1:0] LN2_Q31 = 32'sd1488522236;

endpackage

[hw/rtl/fpnl_front.sv]
// Front end of the logarithm pipeline: domain check, leading-one search and
// normalisation into [1,2). Two register stages. Depends on fpnl_pkg defaults.
module fpnl_front #(
  parameter int FRAC_BITS   = fpnl_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = fpnl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   up_valid,
  output logic                                                   up_ready,
  input  logic [VALUE_WIDTH-1:0]                                 up_value,
  output logic                                                   dn_valid,
  input  logic                                                   dn_ready,
  output logic [FRAC_BITS:0]                                     dn_z,
  output logic [$clog2(VALUE_WIDTH+FRAC_BITS)+FRAC_BITS:0]       dn_y,
  output logic                                                   dn_dom
);

  localparam int ZW   = FRAC_BITS + 1;
  localparam int EW   = $clog2(VALUE_WIDTH + FRAC_BITS) + 1;
  localparam int YW   = EW + FRAC_BITS;
  localparam int MSBW = $clog2(VALUE_WIDTH);
  localparam int WW   = VALUE_WIDTH + FRAC_BITS;

  // First stage: operand, position of its leading one, domain flag.
  logic                   va_r;
  logic [VALUE_WIDTH-1:0] a_r;
  logic [MSBW-1:0]        msb_r;
  logic                   doma_r;
  logic [MSBW-1:0]        msb_nxt;
  logic                   doma_nxt;
  logic                   ready_a;

  // Second stage: mantissa in [1,2) and integer part of the base-2 log.
  logic                   vb_r;
  logic [ZW-1:0]          z_r;
  logic [YW-1:0]          y_r;
  logic                   domb_r;
  logic [ZW-1:0]          z_nxt;
  logic [YW-1:0]          y_nxt;
  logic                   ready_b;

  logic signed [EW-1:0]   e;
  logic signed [EW-1:0]   e_neg;
  logic [WW-1:0]          wide;
  logic [WW-1:0]          wide_sh;

  assign ready_b  = !vb_r || dn_ready;
  assign ready_a  = !va_r || ready_b;
  assign up_ready = ready_a;

  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if (up_value[i]) begin
        msb_nxt = MSBW'(i);
      end
    end
    doma_nxt = (up_value == '0) || up_value[VALUE_WIDTH-1];
  end

  always_comb begin
    e     = {{(EW-MSBW){1'b0}}, msb_r} - EW'(FRAC_BITS);
    e_neg = -e;
    wide  = {{FRAC_BITS{1'b0}}, a_r};
    if (e[EW-1]) begin
      wide_sh = wide << e_neg[EW-2:0];
    end else begin
      wide_sh = wide >> e[EW-2:0];
    end
    z_nxt = wide_sh[ZW-1:0];
    y_nxt = {e, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= up_valid;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      a_r    <= up_value;
      msb_r  <= msb_nxt;
      doma_r <= doma_nxt;
    end
    if (ready_b && va_r) begin
      z_r    <= z_nxt;
      y_r    <= y_nxt;
      domb_r <= doma_r;
    end
  end

  assign dn_valid = vb_r;
  assign dn_z     = z_r;
  assign dn_y     = y_r;
  assign dn_dom   = domb_r;

endmodule

[hw/rtl/fpnl_sq_stage.sv]
// One squaring round of the base-2 logarithm: square, truncate, halve at two
// and set the matching fraction bit. Depends on fpnl_pkg defaults only.
module fpnl_sq_stage #(
  parameter int FRAC_BITS   = fpnl_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = fpnl_pkg::VALUE_WIDTH_DEF,
  parameter int ROUND       = 0
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             up_valid,
  output logic                                             up_ready,
  input  logic [FRAC_BITS:0]                               up_z,
  input  logic [$clog2(VALUE_WIDTH+FRAC_BITS)+FRAC_BITS:0] up_y,
  input  logic                                             up_dom,
  output logic                                             dn_valid,
  input  logic                                             dn_ready,
  output logic [FRAC_BITS:0]                               dn_z,
  output logic [$clog2(VALUE_WIDTH+FRAC_BITS)+FRAC_BITS:0] dn_y,
  output logic                                             dn_dom
);

  localparam int ZW = FRAC_BITS + 1;
  localparam int YW = $clog2(VALUE_WIDTH + FRAC_BITS) + 1 + FRAC_BITS;

  logic            v_r;
  logic [ZW-1:0]   z_r;
  logic [YW-1:0]   y_r;
  logic            dom_r;
  logic [2*ZW-1:0] sq;
  logic [ZW:0]     t;
  logic [ZW-1:0]   z_nxt;
  logic [YW-1:0]   y_nxt;
  logic            ready;

  assign ready    = !v_r || dn_ready;
  assign up_ready = ready;

  // The square of a value in [1,2) lies in [1,4); its top bit says it reached two.
  // The earlier rounds only set higher fraction bits, so setting this bit adds
  // the weight exactly.
  always_comb begin
    sq    = up_z * up_z;
    t     = sq[FRAC_BITS+ZW:FRAC_BITS];
    z_nxt = t[ZW] ? t[ZW:1] : t[ZW-1:0];
    y_nxt = up_y;
    y_nxt[FRAC_BITS-1-ROUND] = t[ZW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      z_r   <= z_nxt;
      y_r   <= y_nxt;
      dom_r <= up_dom;
    end
  end

  assign dn_valid = v_r;
  assign dn_z     = z_r;
  assign dn_y     = y_r;
  assign dn_dom   = dom_r;

endmodule

[hw/rtl/fpnl_scale.sv]
// Conversion of the base-2 logarithm to a natural one: multiply by ln 2 in Q31,
// floor shift, saturate, clear on a domain error. Depends on fpnl_pkg.
module fpnl_scale #(
  parameter int FRAC_BITS   = fpnl_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = fpnl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             up_valid,
  output logic                                             up_ready,
  input  logic [$clog2(VALUE_WIDTH+FRAC_BITS)+FRAC_BITS:0] up_y,
  input  logic                                             up_dom,
  output logic                                             dn_valid,
  input  logic                                             dn_ready,
  output logic [fpnl_pkg::LOG_W-1:0]                       dn_log,
  output logic                                             dn_dom
);

  import fpnl_pkg::*;

  localparam int YW = $clog2(VALUE_WIDTH + FRAC_BITS) + 1 + FRAC_BITS;
  localparam int PW = YW + LN2_W;
  localparam int QW = PW - LN2_SHIFT;
  localparam int LW = QW + LOG_W;
  localparam logic signed [LW-1:0] LOG_HI = LW'((2 ** (LOG_W - 1)) - 1);
  localparam logic signed [LW-1:0] LOG_LO = -LW'(2 ** (LOG_W - 1));

  logic                    vp_r;
  logic signed [PW-1:0]    prod_r;
  logic                    domp_r;
  logic signed [PW-1:0]    prod_nxt;
  logic                    ready_p;

  logic                    vo_r;
  logic [LOG_W-1:0]        log_r;
  logic                    domo_r;
  logic [LOG_W-1:0]        log_nxt;
  logic                    ready_o;

  logic signed [QW-1:0]    ln;
  logic signed [LW-1:0]    lnx;

  assign ready_o  = !vo_r || dn_ready;
  assign ready_p  = !vp_r || ready_o;
  assign up_ready = ready_p;

  assign prod_nxt = $signed(up_y) * LN2_Q31;

  // Dropping the low bits of a two's complement product floors toward minus infinity.
  always_comb begin
    ln  = prod_r[PW-1:LN2_SHIFT];
    lnx = LW'(ln);
    if (domp_r) begin
      log_nxt = '0;
    end else if (lnx > LOG_HI) begin
      log_nxt = LOG_HI[LOG_W-1:0];
    end else if (lnx < LOG_LO) begin
      log_nxt = LOG_LO[LOG_W-1:0];
    end else begin
      log_nxt = lnx[LOG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ready_p) begin
        vp_r <= up_valid;
      end
      if (ready_o) begin
        vo_r <= vp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_p && up_valid) begin
      prod_r <= prod_nxt;
      domp_r <= up_dom;
    end
    if (ready_o && vp_r) begin
      log_r  <= log_nxt;
      domo_r <= domp_r;
    end
  end

  assign dn_valid = vo_r;
  assign dn_log   = log_r;
  assign dn_dom   = domo_r;

endmodule

[hw/rtl/fixed_point_natural_log.sv]
// Top level of the fixed-point natural logarithm pipeline.
// Depends on fpnl_pkg, fpnl_front, fpnl_sq_stage and fpnl_scale.
//
//   Channel   Ports                            Direction   Contents
//   input     in_valid, in_stall, in_value_in  in          signed operand, FRAC_BITS fraction bits
//   result    out_valid, out_stall, out_*      out         natural log and domain flag
//
// The block accepts one item in every clock cycle while in_stall is low. Each
// item passes through the normalisation registers of the front end, the
// squaring rounds, each with its own multiplier and register, then the product
// register after the multiplication by ln 2 and the output register after the
// floor shift and saturation. Reset is synchronous and active low; it clears
// every valid bit, so the pipeline comes out of reset empty. Every stage holds
// its item while the stage behind it is full and stalled, and fills up as soon
// as a place ahead of it is free, so a stall on the result side reaches
// in_stall only once the whole pipeline is full.
module fixed_point_natural_log #(
  parameter int FRAC_BITS   = fpnl_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = fpnl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [VALUE_WIDTH-1:0]     in_value_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fpnl_pkg::LOG_W-1:0] out_log_out,
  output logic                       out_domain_error
);

  import fpnl_pkg::*;

  localparam int ZW = FRAC_BITS + 1;
  localparam int YW = $clog2(VALUE_WIDTH + FRAC_BITS) + 1 + FRAC_BITS;

  // Links between the stages: index k feeds squaring round k, and the last one
  // feeds the scaling stage.
  logic          lnk_valid [FRAC_BITS+1];
  logic          lnk_ready [FRAC_BITS+1];
  logic [ZW-1:0] lnk_z     [FRAC_BITS+1];
  logic [YW-1:0] lnk_y     [FRAC_BITS+1];
  logic          lnk_dom   [FRAC_BITS+1];
  logic          front_ready;

  assign in_stall = !front_ready;

  fpnl_front #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_value (in_value_in),
    .dn_valid (lnk_valid[0]),
    .dn_ready (lnk_ready[0]),
    .dn_z     (lnk_z[0]),
    .dn_y     (lnk_y[0]),
    .dn_dom   (lnk_dom[0])
  );

  // One squaring round per stage; round k decides fraction bit FRAC_BITS-1-k.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_round
    fpnl_sq_stage #(
      .FRAC_BITS  (FRAC_BITS),
      .VALUE_WIDTH(VALUE_WIDTH),
      .ROUND      (k)
    ) u_sq (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lnk_valid[k]),
      .up_ready (lnk_ready[k]),
      .up_z     (lnk_z[k]),
      .up_y     (lnk_y[k]),
      .up_dom   (lnk_dom[k]),
      .dn_valid (lnk_valid[k+1]),
      .dn_ready (lnk_ready[k+1]),
      .dn_z     (lnk_z[k+1]),
      .dn_y     (lnk_y[k+1]),
      .dn_dom   (lnk_dom[k+1])
    );
  end

  // The mantissa is no longer needed once the last round has decided its bit.
  fpnl_scale #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lnk_valid[FRAC_BITS]),
    .up_ready (lnk_ready[FRAC_BITS]),
    .up_y     (lnk_y[FRAC_BITS]),
    .up_dom   (lnk_dom[FRAC_BITS]),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_log   (out_log_out),
    .dn_dom   (out_domain_error)
  );

endmodule

[hw/rtl/fpnl_checker.sv]
// Port-level checker for the fixed-point natural logarithm, with its bind.
// Depends on fpnl_pkg and fixed_point_natural_log_macros.svh.
`include "fixed_point_natural_log_macros.svh"

module fpnl_checker #(
  parameter int FRAC_BITS   = fpnl_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = fpnl_pkg::VALUE_WIDTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [VALUE_WIDTH-1:0]     in_value_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [fpnl_pkg::LOG_W-1:0] out_log_out,
  input logic                       out_domain_error
);

  import fpnl_pkg::*;

  logic [FRAC_BITS-1:0] unused_frac;
  logic                 unused_in;

  assign unused_frac = '0;
  assign unused_in   = in_valid ^ (^in_value_in) ^ (^unused_frac);

  // A result that waits on a stall keeps its value.
  `FPNL_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_log_out) && $stable(out_domain_error), "result changed while stalled")

  // An operand outside the domain gives a zero logarithm.
  `FPNL_ASSERT(a_dom_zero, clk, rst_n, out_valid && out_domain_error |-> out_log_out == '0, "domain error with nonzero result")

  // Every stage refills at once, so the input stalls only behind a full, stalled pipeline.
  `FPNL_ASSERT(a_no_idle_stall, clk, rst_n, !out_valid || !out_stall |-> !in_stall, "input stalled while the result side drains")

  // Reset empties the pipeline.
  `FPNL_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fixed_point_natural_log fpnl_checker #(
  .FRAC_BITS  (FRAC_BITS),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_fpnl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_value_in     (in_value_in),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_log_out     (out_log_out),
  .out_domain_error(out_domain_error)
);
